>>> design/tgad_pkg.sv
// Package for the TGA image decoder: status codes, header offsets, phase codes.
// No dependencies; imported by every module of the decoder.
package tgad_pkg;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd1;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd2;
  localparam logic [1:0] ST_BUSY       = 2'd3;

  // byte offsets inside the 18-byte header
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_ATTR      = 5'd17;

  localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
  localparam logic [7:0] IMG_TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] ATTR_TOP_DOWN = 8'h20;
  localparam logic [7:0] PKT_RUN_BIT   = 8'h80;
  localparam logic [7:0] PKT_COUNT_MSK = 8'h7f;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_IDSKIP = 7'b0000010,
    PH_RAW    = 7'b0000100,
    PH_PACKET = 7'b0001000,
    PH_LIT    = 7'b0010000,
    PH_DRAIN  = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_e;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic        pixel_valid;
    logic [15:0] pixel_row;
    logic [15:0] pixel_column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        run_pending;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

endpackage

>>> design/tgad_decode.sv
// Decoder state and per-request step logic: header parse, packets, pixels.
// Depends on tgad_pkg.
module tgad_decode import tgad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    mode_i,
  input  logic [7:0] data_byte_i,
  output logic    emit_o,
  output result_t res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  hidx_q, hidx_d;
  logic [7:0]  id_skip_q, id_skip_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  map_q, map_d;
  logic [7:0]  bpp_q, bpp_d;
  logic [7:0]  attr_q, attr_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] latch_q, latch_d;
  logic [7:0]  pleft_q, pleft_d;
  logic        is_run_q, is_run_d;
  logic [31:0] run_rgba_q, run_rgba_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [1:0]  err_q, err_d;

  logic [23:0] latch_new;
  logic        need4, pix_last;
  logic [31:0] rgba;
  logic [15:0] dest_row;
  logic [16:0] col_inc, row_inc;
  logic        wrap, adv_done;
  logic        start_img, do_advance;
  logic [7:0]  pleft_dec;

  always_comb begin
    latch_new = latch_q;
    case (bip_q)
      2'd0:    latch_new[7:0]   = latch_q[7:0]   | data_byte_i;
      2'd1:    latch_new[15:8]  = latch_q[15:8]  | data_byte_i;
      2'd2:    latch_new[23:16] = latch_q[23:16] | data_byte_i;
      default: latch_new = latch_q;
    endcase
  end

  assign need4    = (bpp_q != DEPTH_24);
  assign pix_last = need4 ? (bip_q == 2'd3) : (bip_q == 2'd2);
  assign rgba     = {latch_new[23:16], latch_new[15:8], latch_new[7:0],
                     need4 ? data_byte_i : ALPHA_OPAQUE};
  assign dest_row = ((attr_q & ATTR_TOP_DOWN) != 8'd0) ? row_q
                                                        : height_q - 16'd1 - row_q;
  assign col_inc  = {1'b0, col_q} + 17'd1;
  assign row_inc  = {1'b0, row_q} + 17'd1;
  assign wrap     = col_inc >= {1'b0, width_q};
  assign adv_done = wrap && (row_inc >= {1'b0, height_q});
  assign pleft_dec = pleft_q - 8'd1;

  always_comb begin
    phase_d = phase_q;   hidx_d = hidx_q;     id_skip_d = id_skip_q;
    type_d = type_q;     map_d = map_q;       bpp_d = bpp_q;
    attr_d = attr_q;     width_d = width_q;   height_d = height_q;
    bip_d = bip_q;       latch_d = latch_q;   pleft_d = pleft_q;
    is_run_d = is_run_q; run_rgba_d = run_rgba_q;
    col_d = col_q;       row_d = row_q;       err_d = err_q;
    emit_o = 1'b0;
    start_img = 1'b0;
    do_advance = 1'b0;
    res_o = '0;

    case (phase_q)
      PH_ERROR: begin
        emit_o = 1'b1;
        res_o.status = err_q;
      end
      PH_DRAIN: begin
        emit_o = 1'b1;
        if (!mode_i) begin
          res_o.status = ST_BUSY;
        end else begin
          res_o.pixel_valid = 1'b1;
          res_o.pixel_row = dest_row;
          res_o.pixel_column = col_q;
          {res_o.red, res_o.green, res_o.blue, res_o.alpha} = run_rgba_q;
          res_o.image_done = adv_done;
          do_advance = 1'b1;
          pleft_d = pleft_dec;
          if (adv_done) begin
            phase_d = PH_HEADER;
          end else if (pleft_dec == 8'd0) begin
            phase_d = PH_PACKET;
          end
        end
      end
      PH_HEADER: begin
        if (!mode_i) begin
          hidx_d = hidx_q + 5'd1;
          case (hidx_q)
            HDR_ID_LEN:    id_skip_d = data_byte_i;
            HDR_MAP_TYPE:  map_d = data_byte_i;
            HDR_IMG_TYPE:  type_d = data_byte_i;
            HDR_WIDTH_LO:  width_d[7:0] = data_byte_i;
            HDR_WIDTH_HI:  width_d[15:8] = data_byte_i;
            HDR_HEIGHT_LO: height_d[7:0] = data_byte_i;
            HDR_HEIGHT_HI: height_d[15:8] = data_byte_i;
            HDR_DEPTH:     bpp_d = data_byte_i;
            HDR_ATTR:      attr_d = data_byte_i;
            default:       hidx_d = hidx_q + 5'd1;
          endcase
          if (hidx_q == HDR_ATTR) begin
            if (type_q != IMG_TYPE_RAW && type_q != IMG_TYPE_RLE) begin
              err_d = ST_BAD_TYPE;
            end else if (map_q != 8'd0 || (bpp_q != DEPTH_24 && bpp_q != DEPTH_32)) begin
              err_d = ST_BAD_FORMAT;
            end
            if (err_d != ST_OK) begin
              phase_d = PH_ERROR;
              emit_o = 1'b1;
              res_o.status = err_d;
            end else if (id_skip_q != 8'd0) begin
              phase_d = PH_IDSKIP;
            end else begin
              start_img = 1'b1;
            end
          end
        end
      end
      PH_IDSKIP: begin
        if (!mode_i) begin
          id_skip_d = id_skip_q - 8'd1;
          if (id_skip_d == 8'd0) begin
            start_img = 1'b1;
          end
        end
      end
      PH_PACKET: begin
        if (!mode_i) begin
          pleft_d = (data_byte_i & PKT_COUNT_MSK) + 8'd1;
          is_run_d = (data_byte_i & PKT_RUN_BIT) != 8'd0;
          bip_d = 2'd0;
          latch_d = '0;
          phase_d = PH_LIT;
        end
      end
      PH_RAW, PH_LIT: begin
        if (!mode_i) begin
          if (!pix_last) begin
            latch_d = latch_new;
            bip_d = bip_q + 2'd1;
          end else begin
            emit_o = 1'b1;
            bip_d = 2'd0;
            latch_d = '0;
            res_o.pixel_valid = 1'b1;
            res_o.pixel_row = dest_row;
            res_o.pixel_column = col_q;
            {res_o.red, res_o.green, res_o.blue, res_o.alpha} = rgba;
            res_o.image_done = adv_done;
            do_advance = 1'b1;
            if (phase_q == PH_LIT) begin
              pleft_d = pleft_dec;
            end
            if (adv_done) begin
              phase_d = PH_HEADER;
            end else if (phase_q == PH_LIT) begin
              if (pleft_dec == 8'd0) begin
                phase_d = PH_PACKET;
              end else if (is_run_q) begin
                run_rgba_d = rgba;
                phase_d = PH_DRAIN;
              end
            end
          end
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    if (do_advance) begin
      col_d = wrap ? 16'd0 : col_inc[15:0];
      row_d = wrap ? row_inc[15:0] : row_q;
    end

    if (start_img) begin
      col_d = '0;
      row_d = '0;
      bip_d = '0;
      latch_d = '0;
      pleft_d = '0;
      is_run_d = 1'b0;
      if (width_d == 16'd0 || height_d == 16'd0) begin
        // empty image: straight back to a fresh header, even from the header phase
        phase_d = PH_HEADER;
        hidx_d = '0;
        emit_o = 1'b1;
        res_o.image_done = 1'b1;
      end else begin
        phase_d = (type_q == IMG_TYPE_RAW) ? PH_RAW : PH_PACKET;
      end
    end

    // leaving for a new header clears the packet and pixel trackers
    if (phase_d == PH_HEADER && phase_q != PH_HEADER) begin
      hidx_d = '0;
      pleft_d = '0;
      is_run_d = 1'b0;
      bip_d = '0;
      latch_d = '0;
    end

    res_o.run_pending  = (phase_d == PH_DRAIN);
    res_o.image_width  = width_d;
    res_o.image_height = height_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;  hidx_q <= '0;   id_skip_q <= '0;
      type_q <= '0;          map_q <= '0;    bpp_q <= '0;
      attr_q <= '0;          width_q <= '0;  height_q <= '0;
      bip_q <= '0;           latch_q <= '0;  pleft_q <= '0;
      is_run_q <= 1'b0;      run_rgba_q <= '0;
      col_q <= '0;           row_q <= '0;    err_q <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;    hidx_q <= hidx_d;    id_skip_q <= id_skip_d;
      type_q <= type_d;      map_q <= map_d;      bpp_q <= bpp_d;
      attr_q <= attr_d;      width_q <= width_d;  height_q <= height_d;
      bip_q <= bip_d;        latch_q <= latch_d;  pleft_q <= pleft_d;
      is_run_q <= is_run_d;  run_rgba_q <= run_rgba_d;
      col_q <= col_d;        row_q <= row_d;      err_q <= err_d;
    end
  end

endmodule

>>> design/tga_image_decoder_core.sv
// Top level of the TGA image decoder: input register, decode step, result register.
// Depends on tgad_pkg and tgad_decode.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | in_valid_i/in_ready_o  | mode_i, data_byte_i
//  result   | out_valid_o/out_ready_i| status_o .. image_height_o (one port per field)
//
// One request per cycle sustained while results are taken. A request is captured
// in the input register, takes one decode step (the state update) when the result
// register is free or being emptied, and its result, if any, appears the next
// cycle. Reset (async, active low) empties both registers and puts the decoder in
// the header phase. A stalled result holds the result register and a full input
// register, which frees as soon as the result register can take a new value.
module tga_image_decoder_core import tgad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        pixel_valid_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_column_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        run_pending_o,
  output logic        image_done_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);

  // input register
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic [7:0] s1_byte_q;

  // result register
  logic    out_valid_q;
  result_t out_q;

  logic    out_free;   // result register can load this cycle
  logic    step;       // held request takes its decode step
  logic    emit;
  result_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mode_q <= mode_i;
      s1_byte_q <= data_byte_i;
    end
  end

  tgad_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .mode_i      (s1_mode_q),
    .data_byte_i (s1_byte_q),
    .emit_o      (emit),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign pixel_valid_o  = out_q.pixel_valid;
  assign pixel_row_o    = out_q.pixel_row;
  assign pixel_column_o = out_q.pixel_column;
  assign red_o          = out_q.red;
  assign green_o        = out_q.green;
  assign blue_o         = out_q.blue;
  assign alpha_o        = out_q.alpha;
  assign run_pending_o  = out_q.run_pending;
  assign image_done_o   = out_q.image_done;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;

  // a held request waiting on a full result register must not change
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_mode_q) && $stable(s1_byte_q))
    else $error("input register changed while stalled");

  // pixels are only reported with an ok status
  a_pix_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_valid_o |-> status_o == ST_OK)
    else $error("pixel with error status");

  // a refused byte is only reported while a run is still draining
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BUSY |-> run_pending_o && !pixel_valid_o)
    else $error("busy status outside a run");

  // the image end leaves no run behind
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> !run_pending_o && status_o == ST_OK)
    else $error("image end with run pending");

endmodule

>>> verif/tb_tga_image_decoder_core.sv
// Self-checking testbench for tga_image_decoder_core: streams TGA headers, ID fields and
// raw or run-length pixel data, predicts every result and checks it under random stalls.
// Depends on tgad_pkg and the decoder RTL; needs no files or arguments.
import tgad_pkg::*;

class tga_result_scoreboard;
  phase_e      phase;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left, map_type, img_type, depth, attr;
  logic [15:0] width, height, col_cnt, file_row;
  logic [1:0]  byte_idx, err;
  logic [23:0] colour_acc;
  logic [7:0]  pkt_left;
  logic        pkt_is_run;
  logic [31:0] run_rgba;
  result_t     due_results[$];
  int          failures;

  function new();
    to_header();
    id_left = '0; map_type = '0; img_type = '0; depth = '0; attr = '0;
    width = '0; height = '0; col_cnt = '0; file_row = '0;
    err = ST_OK; run_rgba = '0; failures = 0;
  endfunction

  function void to_header();
    phase = PH_HEADER;
    hdr_idx = '0;
    pkt_left = '0;
    pkt_is_run = 1'b0;
    byte_idx = '0;
    colour_acc = '0;
  endfunction

  // run_pending follows the phase after the update
  function result_t shape_result(logic [1:0] st, logic pv, logic [15:0] row,
                                 logic [15:0] col, logic [31:0] rgba, logic done);
    result_t r;
    r.status       = st;
    r.pixel_valid  = pv;
    r.pixel_row    = row;
    r.pixel_column = col;
    r.red          = rgba[31:24];
    r.green        = rgba[23:16];
    r.blue         = rgba[15:8];
    r.alpha        = rgba[7:0];
    r.run_pending  = (phase == PH_DRAIN);
    r.image_done   = done;
    r.image_width  = width;
    r.image_height = height;
    return r;
  endfunction

  function logic [15:0] dest_row();
    if ((attr & ATTR_TOP_DOWN) != 0) return file_row;
    return height - 16'd1 - file_row;
  endfunction

  // step to the next pixel position; 1 once the last row is complete
  function bit advance();
    col_cnt = col_cnt + 16'd1;
    if (col_cnt >= width) begin
      col_cnt = '0;
      file_row = file_row + 16'd1;
      if (file_row >= height) return 1;
    end
    return 0;
  endfunction

  function bit start_image(output result_t r);
    col_cnt = '0;
    file_row = '0;
    byte_idx = '0;
    colour_acc = '0;
    pkt_left = '0;
    pkt_is_run = 1'b0;
    r = '0;
    if (width == 0 || height == 0) begin
      to_header();
      r = shape_result(ST_OK, 1'b0, 16'd0, 16'd0, 32'd0, 1'b1);
      return 1;
    end
    phase = (img_type == IMG_TYPE_RAW) ? PH_RAW : PH_PACKET;
    return 0;
  endfunction

  // decode one accepted request and queue the result it causes, if any
  function void note_request(logic tick, logic [7:0] b);
    result_t     r;
    bit          have;
    logic [4:0]  idx;
    logic [1:0]  last_byte;
    logic [31:0] rgba;
    logic [15:0] row, col;
    bit          done;
    have = 0;
    r = '0;
    if (phase == PH_ERROR) begin
      r = shape_result(err, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0);
      have = 1;
    end else if (phase == PH_DRAIN) begin
      if (!tick) begin
        r = shape_result(ST_BUSY, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0);
      end else begin
        row = dest_row();
        col = col_cnt;
        done = advance();
        pkt_left = pkt_left - 8'd1;
        if (done) to_header();
        else if (pkt_left == 0) phase = PH_PACKET;
        r = shape_result(ST_OK, 1'b1, row, col, run_rgba, done);
      end
      have = 1;
    end else if (!tick) begin
      case (phase)
        PH_HEADER: begin
          idx = hdr_idx;
          hdr_idx = hdr_idx + 5'd1;
          case (idx)
            HDR_ID_LEN:    id_left = b;
            HDR_MAP_TYPE:  map_type = b;
            HDR_IMG_TYPE:  img_type = b;
            HDR_WIDTH_LO:  width[7:0] = b;
            HDR_WIDTH_HI:  width[15:8] = b;
            HDR_HEIGHT_LO: height[7:0] = b;
            HDR_HEIGHT_HI: height[15:8] = b;
            HDR_DEPTH:     depth = b;
            HDR_ATTR:      attr = b;
            default: ;
          endcase
          if (idx == HDR_ATTR) begin
            if (img_type != IMG_TYPE_RAW && img_type != IMG_TYPE_RLE) err = ST_BAD_TYPE;
            else if (map_type != 0 || (depth != DEPTH_24 && depth != DEPTH_32))
              err = ST_BAD_FORMAT;
            if (err != ST_OK) begin
              phase = PH_ERROR;
              r = shape_result(err, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0);
              have = 1;
            end else if (id_left != 0) begin
              phase = PH_IDSKIP;
            end else begin
              have = start_image(r);
            end
          end
        end
        PH_IDSKIP: begin
          id_left = id_left - 8'd1;
          if (id_left == 0) have = start_image(r);
        end
        PH_PACKET: begin
          pkt_left = {1'b0, b[6:0]} + 8'd1;
          pkt_is_run = b[7];
          byte_idx = '0;
          colour_acc = '0;
          phase = PH_LIT;
        end
        PH_RAW, PH_LIT: begin
          last_byte = (depth == DEPTH_24) ? 2'd2 : 2'd3;
          // stored order is B, G, R, then alpha for 32-bit
          if (byte_idx < 3) colour_acc = colour_acc | ({16'd0, b} << (8 * byte_idx));
          if (byte_idx != last_byte) begin
            byte_idx = byte_idx + 2'd1;
          end else begin
            rgba = {colour_acc[23:16], colour_acc[15:8], colour_acc[7:0],
                    (depth == DEPTH_24) ? ALPHA_OPAQUE : b};
            byte_idx = '0;
            colour_acc = '0;
            row = dest_row();
            col = col_cnt;
            done = advance();
            if (phase == PH_LIT) pkt_left = pkt_left - 8'd1;
            if (done) begin
              to_header();
            end else if (phase == PH_LIT) begin
              if (pkt_left == 0) begin
                phase = PH_PACKET;
              end else if (pkt_is_run) begin
                run_rgba = rgba;
                phase = PH_DRAIN;
              end
            end
            r = shape_result(ST_OK, 1'b1, row, col, rgba, done);
            have = 1;
          end
        end
        default: ;
      endcase
    end
    if (have) due_results.push_back(r);
  endfunction

  function string describe(result_t r);
    return $sformatf({"st=%0d pix=%0d row=%0d col=%0d rgba=%02h%02h%02h%02h",
                      " run=%0d done=%0d w=%0d h=%0d"},
                     r.status, r.pixel_valid, r.pixel_row, r.pixel_column, r.red, r.green,
                     r.blue, r.alpha, r.run_pending, r.image_done, r.image_width,
                     r.image_height);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result: %s", describe(got));
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10) begin
        $display("result mismatch");
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction

  function int pending_count();
    return due_results.size();
  endfunction
endclass

module tb_tga_image_decoder_core;

  localparam int LIMIT_CYCLES = 400000;  // slowest legal run is far below this
  localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
  localparam int TAIL_CYCLES  = 8;       // margin for results still in the input and result registers
  localparam int STAGE_ITEMS  = 160;     // random requests per idling stage

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        pixel_valid_o;
  logic [15:0] pixel_row_o, pixel_column_o;
  logic [7:0]  red_o, green_o, blue_o, alpha_o;
  logic        run_pending_o, image_done_o;
  logic [15:0] image_width_o, image_height_o;

  result_t seen;

  tga_result_scoreboard sb = new();

  int cycles = 0;
  int items_sent = 0;
  int send_idle_pct = 17;
  int recv_idle_pct = 63;
  // hold-off handshake between stimulus and receiver: each side writes its own counter
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  tga_image_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .run_pending_o  (run_pending_o),
    .image_done_o   (image_done_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  always #5 clk_i = ~clk_i;

  // result ports gathered in result_t field order
  assign seen = {status_o, pixel_valid_o, pixel_row_o, pixel_column_o, red_o, green_o,
                 blue_o, alpha_o, run_pending_o, image_done_o, image_width_o, image_height_o};

  // Monitor: sampled at the edge, before any nonblocking update of that edge lands.
  // A request is predicted when it is accepted; the decoder's input and result registers
  // mean its result can never be checked at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(mode_i, data_byte_i);
      if (out_valid_o && out_ready_i) sb.check_result(seen);
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once the stimulus asks.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one request, with an optional random gap first, and wait for acceptance.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_request(input logic tick, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i <= tick;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_pixel(input bit deep);
    repeat (deep ? 4 : 3) send_request(1'b0, 8'($urandom_range(255)));
  endtask

  // 18-byte header; the unused colour-map spec and origin bytes get random filler
  task automatic send_header(input logic [7:0] id_len, input logic [7:0] map,
                             input logic [7:0] kind, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] bpp,
                             input logic [7:0] attr);
    send_request(1'b0, id_len);
    send_request(1'b0, map);
    send_request(1'b0, kind);
    repeat (9) send_request(1'b0, 8'($urandom_range(255)));
    send_request(1'b0, w[7:0]);
    send_request(1'b0, w[15:8]);
    send_request(1'b0, h[7:0]);
    send_request(1'b0, h[15:8]);
    send_request(1'b0, bpp);
    send_request(1'b0, attr);
  endtask

  // One well-formed image. Run-length packets have random kind and length and may
  // straddle rows; a packet that overruns the image end is cut short, as the source
  // withholds the rest. Stray ticks (ignored) and refused bytes during runs are mixed in.
  task automatic send_image(input bit rle, input bit deep, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] id_len);
    int left;
    int count;
    int k;
    bit is_run;
    send_header(id_len, 8'd0, rle ? IMG_TYPE_RLE : IMG_TYPE_RAW, w, h,
                deep ? DEPTH_32 : DEPTH_24, 8'($urandom_range(255)));
    repeat (id_len) send_request(1'b0, 8'($urandom_range(255)));
    left = int'(w) * int'(h);
    while (left > 0) begin
      if ($urandom_range(19) == 0) send_request(1'b1, 8'($urandom_range(255)));
      if (!rle) begin
        send_pixel(deep);
        left--;
      end else begin
        count = ($urandom_range(7) == 0) ? $urandom_range(128, 1) : $urandom_range(4, 1);
        is_run = 1'($urandom_range(1));
        send_request(1'b0, {is_run, 7'(count - 1)});
        send_pixel(deep);
        left--;
        for (k = 1; k < count && left > 0; k++) begin
          if (is_run) begin
            if ($urandom_range(9) == 0) send_request(1'b0, 8'($urandom_range(255)));
            send_request(1'b1, 8'($urandom_range(255)));
          end else begin
            send_pixel(deep);
          end
          left--;
        end
      end
    end
  endtask

  // Sender pause: drop valid and wait until every predicted result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  initial begin
    int          stage;
    int          sel;
    int          bad_kind;
    bit          rle, deep;
    logic [15:0] w, h;
    logic [7:0]  id_len, kind, map, bpp;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick in the header phase is ignored; then an empty image with maximum
    // width, zero height and a two-byte ID field ends on the last ID byte.
    send_request(1'b1, 8'hFF);
    send_header(8'd2, 8'd0, IMG_TYPE_RLE, 16'hFFFF, 16'h0000, DEPTH_32, 8'hFF);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFF);

    // Random images in three idling stages: slow receiver, slow sender, no idling.
    for (stage = 0; stage < 3; stage++) begin
      wait_drained();
      send_idle_pct = (stage == 0) ? 17 : (stage == 1) ? 63 : 0;
      recv_idle_pct = (stage == 0) ? 63 : (stage == 1) ? 17 : 0;
      if (stage == 1) send_image(1'b1, 1'b0, 16'd3, 16'd2, 8'd255);  // longest ID field
      if (stage == 2) begin
        // receiver holds off while a raw image streams in, so both registers fill
        hold_requests <= hold_requests + 1;
        send_image(1'b0, 1'b1, 16'd6, 16'd4, 8'd0);
      end
      while (items_sent < (stage + 1) * STAGE_ITEMS) begin
        rle = 1'($urandom_range(1));
        deep = 1'($urandom_range(1));
        id_len = ($urandom_range(3) == 0) ? 8'($urandom_range(3, 1)) : 8'd0;
        sel = $urandom_range(15);
        if (sel == 0) begin
          w = 16'($urandom_range(65535));
          h = 16'd0;
        end else if (sel == 1) begin
          w = 16'd0;
          h = 16'($urandom_range(65535));
        end else if (sel == 2) begin
          w = 16'($urandom_range(40, 8));
          h = 16'($urandom_range(4, 1));
        end else begin
          w = 16'($urandom_range(6, 1));
          h = 16'($urandom_range(4, 1));
        end
        send_image(rle, deep, w, h, id_len);
      end
    end

    // Bad header last: the error is sticky until reset, and reset is not repeated.
    kind = IMG_TYPE_RAW;
    map = 8'd0;
    bpp = DEPTH_24;
    bad_kind = $urandom_range(2);
    if (bad_kind == 0) begin
      do kind = 8'($urandom_range(255));
      while (kind == IMG_TYPE_RAW || kind == IMG_TYPE_RLE);
    end else if (bad_kind == 1) begin
      kind = IMG_TYPE_RLE;
      map = 8'($urandom_range(255, 1));
    end else begin
      do bpp = 8'($urandom_range(255));
      while (bpp == DEPTH_24 || bpp == DEPTH_32);
    end
    send_header(8'($urandom_range(255)), map, kind, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), bpp, 8'($urandom_range(255)));
    repeat (6) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_count() != 0) begin
      sb.failures++;
      $display("%0d predicted results never arrived", sb.pending_count());
    end
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", sb.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> tga_image_decoder_core.f
design/tgad_pkg.sv
design/tgad_decode.sv
design/tga_image_decoder_core.sv
verif/tb_tga_image_decoder_core.sv
